[rtl/woc_pkg.sv]
// ============================================================================
// woc_pkg: shared definitions for the weight-ordered code converter
// Function codes, the stage control struct and the binomial helpers used to
// build constant tables at elaboration.
// ============================================================================
`default_nettype none

package woc_pkg;

    // Default code width and fixed port widths
    localparam int WIDTH_DEF = 16;
    localparam int WORD_W    = 16;
    localparam int FUNC_W    = 2;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_BIN_TO_E  = 2'd0,
        FUNC_GRAY_TO_E = 2'd1,
        FUNC_E_TO_BIN  = 2'd2,
        FUNC_E_TO_GRAY = 2'd3
    } t_func;

    // Control that travels with each transaction down the chain
    typedef struct packed {
        logic vld;   // stage holds a transaction
        logic rank;  // 1: word to index, 0: index to word
        logic gray;  // Gray stage in front of unrank or behind rank
        logic err;   // conversion disabled
    } t_ctrl;

    // Binomial coefficient C(n, k) through Pascal's triangle (constant use only)
    function automatic int unsigned binom(input int n, input int k);
        int unsigned row [0:31];
        int          i;
        int          j;
        for (i = 0; i < 32; i++) begin
            row[i] = 0;
        end
        row[0] = 1;
        for (i = 1; i <= n; i++) begin
            for (j = i; j >= 1; j--) begin
                row[j] = row[j] + row[j-1];
            end
        end
        if (k < 0 || k > n || k > 31) begin
            return 0;
        end
        return row[k];
    endfunction

    // Index of the first word of weight k: sum of C(w, j) for j < k
    function automatic int unsigned weight_base(input int w, input int k);
        int unsigned s;
        int          j;
        s = 0;
        for (j = 0; j < k; j++) begin
            s = s + binom(w, j);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/woc_search_cell.sv]
// ============================================================================
// woc_search_cell: one step of the weight search
// For an unrank transaction still at weight IDX, subtracts C(WIDTH, IDX) from
// the index if it fits and moves on to the next weight.
// ============================================================================
`default_nettype none

module woc_search_cell #(
    parameter int WIDTH = woc_pkg::WIDTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire woc_pkg::t_ctrl               i_ctrl,
    input  wire logic [WIDTH-1:0]             i_acc,
    input  wire logic [WIDTH-1:0]             i_bits,
    input  wire logic [$clog2(WIDTH+1)-1:0]   i_cnt,
    output woc_pkg::t_ctrl                    o_ctrl,
    output logic [WIDTH-1:0]                  o_acc,
    output logic [WIDTH-1:0]                  o_bits,
    output logic [$clog2(WIDTH+1)-1:0]        o_cnt
);

    localparam int CW = $clog2(WIDTH+1);
    localparam logic [WIDTH-1:0] C_WK  = WIDTH'(woc_pkg::binom(WIDTH, IDX));
    localparam logic [CW-1:0]    IDX_C = CW'(IDX);

    woc_pkg::t_ctrl      r_ctrl;
    logic [WIDTH-1:0]    r_acc;
    logic [WIDTH-1:0]    r_bits;
    logic [CW-1:0]       r_cnt;
    logic                take;
    logic [WIDTH-1:0]    n_acc;
    logic [CW-1:0]       n_cnt;

    // Still searching at this weight and the whole group lies below the index
    always_comb begin
        take  = !i_ctrl.rank && (i_cnt == IDX_C) && (i_acc >= C_WK);
        n_acc = take ? (i_acc - C_WK) : i_acc;
        n_cnt = take ? (i_cnt + CW'(1)) : i_cnt;
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_bits <= i_bits;
            r_cnt  <= n_cnt;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_acc  = r_acc;
    assign o_bits = r_bits;
    assign o_cnt  = r_cnt;

endmodule

`default_nettype wire

[rtl/woc_bit_cell.sv]
// ============================================================================
// woc_bit_cell: one bit position of the rank / unrank chain
// Rank handles bit IDX (LSB first) and adds C(IDX, ones seen). Unrank handles
// bit WIDTH-1-IDX (MSB first) and places a one where C(p, k) fits the index.
// ============================================================================
`default_nettype none

module woc_bit_cell #(
    parameter int WIDTH = woc_pkg::WIDTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire woc_pkg::t_ctrl               i_ctrl,
    input  wire logic [WIDTH-1:0]             i_acc,
    input  wire logic [WIDTH-1:0]             i_bits,
    input  wire logic [$clog2(WIDTH+1)-1:0]   i_cnt,
    output woc_pkg::t_ctrl                    o_ctrl,
    output logic [WIDTH-1:0]                  o_acc,
    output logic [WIDTH-1:0]                  o_bits,
    output logic [$clog2(WIDTH+1)-1:0]        o_cnt
);

    localparam int CW = $clog2(WIDTH+1);
    localparam int PR = IDX;
    localparam int PU = WIDTH - 1 - IDX;

    logic [WIDTH-1:0]    tab_r [0:WIDTH];
    logic [WIDTH-1:0]    tab_u [0:WIDTH];
    woc_pkg::t_ctrl      r_ctrl;
    logic [WIDTH-1:0]    r_acc;
    logic [WIDTH-1:0]    r_bits;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       seen1;
    logic [WIDTH-1:0]    c_u;
    logic [WIDTH-1:0]    n_acc;
    logic [WIDTH-1:0]    n_bits;
    logic [CW-1:0]       n_cnt;

    // Constant coefficient rows for this cell's two positions
    for (genvar g = 0; g <= WIDTH; g++) begin : g_tab
        assign tab_r[g] = WIDTH'(woc_pkg::binom(PR, g));
        assign tab_u[g] = WIDTH'(woc_pkg::binom(PU, g));
    end

    // Step logic: one add for rank, one compare and subtract for unrank
    always_comb begin
        seen1  = i_cnt + CW'(1);
        c_u    = tab_u[i_cnt];
        n_acc  = i_acc;
        n_bits = i_bits;
        n_cnt  = i_cnt;
        if (i_ctrl.rank) begin
            if (i_bits[PR]) begin
                n_acc = i_acc + tab_r[seen1];
                n_cnt = seen1;
            end
        end else if ((i_cnt != '0) && (c_u <= i_acc)) begin
            n_bits[PU] = 1'b1;
            n_acc      = i_acc - c_u;
            n_cnt      = i_cnt - CW'(1);
        end
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_acc  = r_acc;
    assign o_bits = r_bits;
    assign o_cnt  = r_cnt;

endmodule

`default_nettype wire

[rtl/weight_ordered_code_converter.sv]
// ============================================================================
// weight_ordered_code_converter: E-code rank / unrank with Gray option
// Converts words to and from their index in the order by weight, then by
// value, through a chain of cells: WIDTH weight-search cells followed by
// WIDTH bit cells, with an output register and a skid register.
// ============================================================================
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------
//  in       | input     | i_in_valid / o_in_ready     | i_func, i_word
//  out      | output    | o_out_valid / i_out_ready   | o_result, o_error
//  cfg      | input     | i_cfg_valid / o_cfg_ready   | i_cfg_ecode_enabled
//
//  One transaction per clock sustained while the skid register is empty; each
//  stage of the chain does one step. A result passes through the input
//  register, WIDTH search cells, WIDTH bit cells and the output register.
//  Reset clears all stage valids and sets ecode_enabled to 1.
//  With i_out_ready low the skid register takes one more result, then
//  o_in_ready drops until the skid register drains. o_cfg_ready is always 1.
// ============================================================================
`default_nettype none

module weight_ordered_code_converter #(
    parameter int WIDTH = woc_pkg::WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [woc_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [woc_pkg::WORD_W-1:0]    i_word,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [woc_pkg::WORD_W-1:0]         o_result,
    output logic                               o_error,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_ecode_enabled
);

    localparam int CW    = $clog2(WIDTH+1);
    localparam int LAST  = 2 * WIDTH;
    localparam int WW    = woc_pkg::WORD_W;

    logic                r_ecode_en;
    logic                en;
    woc_pkg::t_ctrl      chain_ctrl [0:LAST];
    logic [WIDTH-1:0]    chain_acc  [0:LAST];
    logic [WIDTH-1:0]    chain_bits [0:LAST];
    logic [CW-1:0]       chain_cnt  [0:LAST];
    woc_pkg::t_ctrl      r_f_ctrl;
    logic [WIDTH-1:0]    r_f_acc;
    logic [WIDTH-1:0]    r_f_bits;
    woc_pkg::t_ctrl      n_f_ctrl;
    logic [WIDTH-1:0]    n_f_acc;
    logic [WIDTH-1:0]    n_f_bits;
    logic [WIDTH-1:0]    w_in;
    logic [WIDTH-1:0]    g_bin;
    logic [WIDTH-1:0]    base_tab [0:WIDTH];
    logic [WIDTH-1:0]    tail_r;
    logic [WW-1:0]       tail_res;
    logic                tail_err;
    logic                r_out_valid;
    logic [WW-1:0]       r_out_result;
    logic                r_out_error;
    logic                r_skid_valid;
    logic [WW-1:0]       r_skid_result;
    logic                r_skid_error;
    logic                n_out_valid;
    logic [WW-1:0]       n_out_result;
    logic                n_out_error;
    logic                n_skid_valid;
    logic [WW-1:0]       n_skid_result;
    logic                n_skid_error;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecode_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_ecode_en <= i_cfg_ecode_enabled;
        end
    end

    // Chain advances whenever the skid register is free
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // Front end: decode request, Gray-to-binary prefix XOR on the index
    always_comb begin
        w_in  = WIDTH'(i_word);
        g_bin = w_in;
        for (int s = 0; s < 5; s++) begin
            g_bin = g_bin ^ (g_bin >> (1 << s));
        end
        n_f_ctrl.vld = i_in_valid;
        n_f_ctrl.err = !r_ecode_en;
        unique case (woc_pkg::t_func'(i_func))
            woc_pkg::FUNC_BIN_TO_E: begin
                n_f_ctrl.rank = 1'b0;
                n_f_ctrl.gray = 1'b0;
            end
            woc_pkg::FUNC_GRAY_TO_E: begin
                n_f_ctrl.rank = 1'b0;
                n_f_ctrl.gray = 1'b1;
            end
            woc_pkg::FUNC_E_TO_BIN: begin
                n_f_ctrl.rank = 1'b1;
                n_f_ctrl.gray = 1'b0;
            end
            woc_pkg::FUNC_E_TO_GRAY: begin
                n_f_ctrl.rank = 1'b1;
                n_f_ctrl.gray = 1'b1;
            end
            default: begin
                n_f_ctrl.rank = 1'b0;
                n_f_ctrl.gray = 1'b0;
            end
        endcase
        if (n_f_ctrl.rank) begin
            n_f_acc  = '0;
            n_f_bits = w_in;
        end else begin
            n_f_acc  = n_f_ctrl.gray ? g_bin : w_in;
            n_f_bits = '0;
        end
    end

    // Input register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctrl <= '0;
        end else if (en) begin
            r_f_ctrl <= n_f_ctrl;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_acc  <= n_f_acc;
            r_f_bits <= n_f_bits;
        end
    end

    assign chain_ctrl[0] = r_f_ctrl;
    assign chain_acc[0]  = r_f_acc;
    assign chain_bits[0] = r_f_bits;
    assign chain_cnt[0]  = '0;

    // Weight search cells, then bit cells
    for (genvar i = 0; i < WIDTH; i++) begin : g_search
        woc_search_cell #(
            .WIDTH (WIDTH),
            .IDX   (i)
        ) u_search (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (chain_ctrl[i]),
            .i_acc   (chain_acc[i]),
            .i_bits  (chain_bits[i]),
            .i_cnt   (chain_cnt[i]),
            .o_ctrl  (chain_ctrl[i+1]),
            .o_acc   (chain_acc[i+1]),
            .o_bits  (chain_bits[i+1]),
            .o_cnt   (chain_cnt[i+1])
        );
    end

    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
        woc_bit_cell #(
            .WIDTH (WIDTH),
            .IDX   (i)
        ) u_bit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (chain_ctrl[WIDTH+i]),
            .i_acc   (chain_acc[WIDTH+i]),
            .i_bits  (chain_bits[WIDTH+i]),
            .i_cnt   (chain_cnt[WIDTH+i]),
            .o_ctrl  (chain_ctrl[WIDTH+i+1]),
            .o_acc   (chain_acc[WIDTH+i+1]),
            .o_bits  (chain_bits[WIDTH+i+1]),
            .o_cnt   (chain_cnt[WIDTH+i+1])
        );
    end

    // Start index of each weight group
    for (genvar g = 0; g <= WIDTH; g++) begin : g_base
        assign base_tab[g] = WIDTH'(woc_pkg::weight_base(WIDTH, g));
    end

    // Back end: add group start for rank, optional binary-to-Gray
    always_comb begin
        tail_r = chain_acc[LAST] + base_tab[chain_cnt[LAST]];
        if (chain_ctrl[LAST].gray) begin
            tail_r = tail_r ^ (tail_r >> 1);
        end
        if (!chain_ctrl[LAST].rank) begin
            tail_r = chain_bits[LAST];
        end
        tail_err = chain_ctrl[LAST].err;
        tail_res = tail_err ? '0 : WW'(tail_r);
    end

    // Output register with skid register
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_result  = r_out_result;
        n_out_error   = r_out_error;
        n_skid_valid  = r_skid_valid;
        n_skid_result = r_skid_result;
        n_skid_error  = r_skid_error;
        if (r_skid_valid) begin
            if (i_out_ready) begin
                n_out_result = r_skid_result;
                n_out_error  = r_skid_error;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || i_out_ready) begin
            n_out_valid  = chain_ctrl[LAST].vld;
            n_out_result = tail_res;
            n_out_error  = tail_err;
        end else if (chain_ctrl[LAST].vld) begin
            n_skid_valid  = 1'b1;
            n_skid_result = tail_res;
            n_skid_error  = tail_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_result  <= n_out_result;
        r_out_error   <= n_out_error;
        r_skid_result <= n_skid_result;
        r_skid_error  <= n_skid_error;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;
    assign o_error     = r_out_error;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An error result carries a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_result == '0)
        else $error("error result with nonzero word");

    // Skid register only fills behind a held output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full with empty output register");

    // Skid register fills only when the consumer stalled a valid result
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid register filled without a stall");

    // Unrank uses up exactly the weight and the index it started with
    a_unrank_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_ctrl[LAST].vld && !chain_ctrl[LAST].rank
            |-> chain_cnt[LAST] == '0 && chain_acc[LAST] == '0)
        else $error("unrank left ones or index unplaced");

endmodule

`default_nettype wire
